### src/wlzom_pkg.sv
`timescale 1ns / 1ps

package wlzom_pkg;

   localparam int NUM_LAYERS_DEF = 256;
   localparam int ID_BITS        = 8;
   localparam int LEVEL_BITS     = 10;
   localparam int COORD_BITS     = 12;
   localparam int REQ_DATA_BITS  = 80;
   localparam int RSP_DATA_BITS  = 80;

   localparam logic [2:0] OP_ALLOC  = 3'd0;
   localparam logic [2:0] OP_SIZE   = 3'd1;
   localparam logic [2:0] OP_HEIGHT = 3'd2;
   localparam logic [2:0] OP_MOVE   = 3'd3;
   localparam logic [2:0] OP_FREE   = 3'd4;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_MAP    = 2'd1;
   localparam logic [1:0] KIND_REDRAW = 2'd2;

   localparam logic CSR_SCREEN_W = 1'b0;
   localparam logic CSR_SCREEN_H = 1'b1;

   localparam logic [COORD_BITS-1:0] SCREEN_W_RST = 12'd320;
   localparam logic [COORD_BITS-1:0] SCREEN_H_RST = 12'd200;

   typedef enum logic [1:0] {
      PLAN_REPLY = 2'd0,
      PLAN_MOVE  = 2'd1,
      PLAN_SHIFT = 2'd2
   } plan_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic scan;
      logic shift_rd;
      logic shift_wr;
      logic final_wr;
      logic emit;
      logic reply;
   } cmd_type;

   typedef struct packed {
      logic     req_alloc;
      plan_type plan;
      logic     scan_hit;
      logic     scan_end;
      logic     shift_done;
      logic     emit_last;
      logic     out_free;
   } status_type;

endpackage

### src/window_layer_z_order_manager.sv
`timescale 1ns / 1ps

// Window layer z-order manager. Keeps a pool of NUM_LAYERS layers and the stack
// that orders the visible ones, and answers each command beat with one to four
// result beats: a reply (kind 0) or damage rectangles clipped to the screen for
// owner-map recompute (kind 1) and pixel redraw (kind 2); tlast marks the final
// beat of a command. Commands are handled one at a time. Allocate scans the slot
// bits one per cycle. A height change or a free of a visible layer moves every
// stack entry between the old and new level through the single level-table port,
// reading and then writing each entry in turn. The block needs no clearing pass
// after reset.
module window_layer_z_order_manager #(
   parameter int NUM_LAYERS = wlzom_pkg::NUM_LAYERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // layer_id, requested_level, pos_x, pos_y, layer_width, layer_height, key_color
   input  logic [wlzom_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // operation
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_layer, ok, rect_x0, rect_y0, rect_x1, rect_y1, level_low, level_high
   output logic [wlzom_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // kind
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [wlzom_pkg::COORD_BITS-1:0]    csr_wdata
);
   import wlzom_pkg::*;

   cmd_type    cmd;
   status_type st;

   wlzom_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .st         (st)
   );

   wlzom_dp #(
      .NUM_LAYERS (NUM_LAYERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

### src/wlzom_ctrl.sv
`timescale 1ns / 1ps

module wlzom_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output wlzom_pkg::cmd_type     cmd,
   input  wlzom_pkg::status_type  st
);
   import wlzom_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LOAD     = 8'b0000_0010,
      S_SCAN     = 8'b0000_0100,
      S_SHIFT_RD = 8'b0000_1000,
      S_SHIFT_WR = 8'b0001_0000,
      S_FINAL    = 8'b0010_0000,
      S_EMIT     = 8'b0100_0000,
      S_REPLY    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = st.req_alloc ? S_SCAN : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            case (st.plan)
               PLAN_MOVE:  state_in = S_EMIT;
               PLAN_SHIFT: state_in = S_SHIFT_RD;
               default:    state_in = S_REPLY;
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (st.scan_hit || st.scan_end) state_in = S_REPLY;
         end
         S_SHIFT_RD: begin
            if (st.shift_done) begin
               state_in = S_FINAL;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FINAL: begin
            cmd.final_wr = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.emit_last) state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (st.out_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### src/wlzom_dp.sv
`timescale 1ns / 1ps

module wlzom_dp #(
   parameter int NUM_LAYERS = wlzom_pkg::NUM_LAYERS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [wlzom_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic [2:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [wlzom_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic [1:0]                              rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_wr_en,
   input  logic                                    csr_index,
   input  logic [wlzom_pkg::COORD_BITS-1:0]        csr_wdata,
   input  wlzom_pkg::cmd_type                      cmd,
   output wlzom_pkg::status_type                   st
);
   import wlzom_pkg::*;

   localparam int LW = (NUM_LAYERS > 2) ? $clog2(NUM_LAYERS) : 1;
   localparam int CB = COORD_BITS;
   localparam logic signed [LEVEL_BITS-1:0] LVL_NONE = '1;
   localparam logic signed [LEVEL_BITS-1:0] LVL_ONE  = LEVEL_BITS'(1);

   function automatic logic [CB-1:0] clip(input logic signed [CB+1:0] v,
                                          input logic [CB-1:0] lim);
      logic [CB-1:0] r;
      if (v < 0)                          r = '0;
      else if (v > $signed({2'b00, lim})) r = lim;
      else                                r = v[CB-1:0];
      return r;
   endfunction

   function automatic logic [RSP_DATA_BITS-1:0] pack(
      input logic [7:0] layer, input logic ok,
      input logic [CB-1:0] x0, input logic [CB-1:0] y0,
      input logic [CB-1:0] x1, input logic [CB-1:0] y1,
      input logic [7:0] lo, input logic [8:0] hi);
      return {6'b0, hi, lo, y1, x1, y0, x0, ok, layer};
   endfunction

   // Captured request.
   logic [2:0]                   op_ff;
   logic [ID_BITS-1:0]           id_ff;
   logic signed [LEVEL_BITS-1:0] req_lvl_ff;
   logic signed [CB-1:0]         nx_ff, ny_ff;
   logic [CB-1:0]                nw_ff, nh_ff;

   // Per-layer and per-level stores.
   logic [ID_BITS-1:0]   lal_mem [NUM_LAYERS];
   logic signed [8:0]    lol_mem [NUM_LAYERS];
   logic signed [CB-1:0] ox_mem  [NUM_LAYERS];
   logic signed [CB-1:0] oy_mem  [NUM_LAYERS];
   logic [CB-1:0]        w_mem   [NUM_LAYERS];
   logic [CB-1:0]        h_mem   [NUM_LAYERS];

   logic [ID_BITS-1:0]   lal_rd_ff;
   logic signed [8:0]    old_rd_ff;
   logic signed [CB-1:0] ox_rd_ff, oy_rd_ff;
   logic [CB-1:0]        w_rd_ff, h_rd_ff;

   logic [NUM_LAYERS-1:0] slot_ff, slot_in;
   logic signed [8:0]     top_ff, top_in;
   logic [CB-1:0]         sw_ff, sh_ff;

   logic signed [LEVEL_BITS-1:0] k_ff, k_in, end_ff, end_in, h_ff, h_in;
   logic down_ff, down_in, hid_ff, hid_in, ins_ff, ins_in, lower_ff, lower_in;
   logic [LW-1:0] scan_k_ff, scan_k_in;

   logic [1:0]        dk_ff   [4];
   logic [1:0]        dk_in   [4];
   logic [7:0]        dlo_ff  [4];
   logic [7:0]        dlo_in  [4];
   logic signed [8:0] dhi_ff  [4];
   logic signed [8:0] dhi_in  [4];
   logic [3:0]        dnew_ff, dnew_in;
   logic [1:0]        dlast_ff, dlast_in, e_ff, e_in;

   logic [7:0] reply_layer_ff, reply_layer_in;
   logic       reply_ok_ff, reply_ok_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Write ports.
   logic                 lal_we, lol_we, org_we, size_we;
   logic [LW-1:0]        lal_wa, lol_wa, lal_ra;
   logic [ID_BITS-1:0]   lal_wd;
   logic signed [8:0]    lol_wd;

   logic [LW-1:0]                id_idx, cap_idx;
   logic                         valid;
   logic signed [LEVEL_BITS-1:0] old_l, top_l, req_l, hc, src;
   logic                         visible;
   plan_type                     plan;

   logic signed [CB-1:0]   xs, ys;
   logic signed [CB+1:0]   xe0, ye0, xe1, ye1;

   assign id_idx  = id_ff[LW-1:0];
   assign cap_idx = req_tdata[LW-1:0];
   assign valid   = ({1'b0, id_ff} < 9'(NUM_LAYERS)) && slot_ff[id_idx];
   assign old_l   = {old_rd_ff[8], old_rd_ff};
   assign top_l   = {top_ff[8], top_ff};
   assign req_l   = (op_ff == OP_FREE) ? LVL_NONE : req_lvl_ff;
   assign visible = !old_rd_ff[8];
   assign src     = down_ff ? (k_ff - LVL_ONE) : (k_ff + LVL_ONE);
   assign lal_ra  = src[LW-1:0];

   always_comb begin
      hc = req_l;
      if (req_l > top_l) hc = top_l + LVL_ONE;
      if (visible && hc > top_l) hc = top_l;
      if (hc < LVL_NONE) hc = LVL_NONE;
   end

   always_comb begin
      plan = PLAN_REPLY;
      if (valid) begin
         case (op_ff)
            OP_MOVE:   plan = visible ? PLAN_MOVE : PLAN_REPLY;
            OP_HEIGHT: plan = (hc != old_l) ? PLAN_SHIFT : PLAN_REPLY;
            OP_FREE:   plan = (visible && hc != old_l) ? PLAN_SHIFT : PLAN_REPLY;
            default:   plan = PLAN_REPLY;
         endcase
      end
   end

   always_comb begin
      xs  = dnew_ff[e_ff] ? nx_ff : ox_rd_ff;
      ys  = dnew_ff[e_ff] ? ny_ff : oy_rd_ff;
      xe0 = {{2{xs[CB-1]}}, xs};
      ye0 = {{2{ys[CB-1]}}, ys};
      xe1 = xe0 + $signed({2'b00, w_rd_ff});
      ye1 = ye0 + $signed({2'b00, h_rd_ff});
   end

   assign st.req_alloc  = (req_tuser == OP_ALLOC);
   assign st.plan       = plan;
   assign st.scan_hit   = !slot_ff[scan_k_ff];
   assign st.scan_end   = (scan_k_ff == LW'(NUM_LAYERS - 1));
   assign st.shift_done = down_ff ? !(k_ff > end_ff) : !(k_ff < end_ff);
   assign st.emit_last  = (e_ff == dlast_ff);
   assign st.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      slot_in        = slot_ff;
      top_in         = top_ff;
      k_in           = k_ff;
      end_in         = end_ff;
      h_in           = h_ff;
      down_in        = down_ff;
      hid_in         = hid_ff;
      ins_in         = ins_ff;
      lower_in       = lower_ff;
      scan_k_in      = scan_k_ff;
      dk_in          = dk_ff;
      dlo_in         = dlo_ff;
      dhi_in         = dhi_ff;
      dnew_in        = dnew_ff;
      dlast_in       = dlast_ff;
      e_in           = e_ff;
      reply_layer_in = reply_layer_ff;
      reply_ok_in    = reply_ok_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      lal_we = 1'b0; lal_wa = '0; lal_wd = '0;
      lol_we = 1'b0; lol_wa = '0; lol_wd = '0;
      org_we = 1'b0; size_we = 1'b0;

      if (cmd.capture) begin
         scan_k_in = '0;
      end

      if (cmd.load) begin
         reply_layer_in = '0;
         reply_ok_in    = 1'b1;
         e_in           = '0;
         h_in           = hc;
         hid_in         = 1'b0;
         ins_in         = 1'b0;
         lower_in       = 1'b0;
         if (hc < old_l) begin
            if (hc >= 0) begin
               down_in = 1'b1; k_in = old_l; end_in = hc; lower_in = 1'b1;
            end else begin
               down_in = 1'b0; k_in = old_l; end_in = top_l; hid_in = 1'b1;
            end
         end else begin
            if (visible) begin
               down_in = 1'b0; k_in = old_l; end_in = hc;
            end else begin
               down_in = 1'b1; k_in = top_l + LVL_ONE; end_in = hc; ins_in = 1'b1;
            end
         end
         if (valid && op_ff == OP_SIZE) size_we = 1'b1;
         if (valid && op_ff == OP_MOVE) org_we = 1'b1;
         if (valid && op_ff == OP_FREE) slot_in[id_idx] = 1'b0;
         dk_in[0] = KIND_MAP;    dlo_in[0] = '0;            dhi_in[0] = top_ff;
         dk_in[1] = KIND_MAP;    dlo_in[1] = old_rd_ff[7:0]; dhi_in[1] = top_ff;
         dk_in[2] = KIND_REDRAW; dlo_in[2] = '0;            dhi_in[2] = old_rd_ff - 9'sd1;
         dk_in[3] = KIND_REDRAW; dlo_in[3] = old_rd_ff[7:0]; dhi_in[3] = old_rd_ff;
         dnew_in  = 4'b1010;
         dlast_in = 2'd3;
      end

      if (cmd.scan) begin
         if (!slot_ff[scan_k_ff]) begin
            slot_in[scan_k_ff] = 1'b1;
            lol_we         = 1'b1;
            lol_wa         = scan_k_ff;
            lol_wd         = '1;
            reply_layer_in = 8'(scan_k_ff);
            reply_ok_in    = 1'b1;
         end else if (scan_k_ff == LW'(NUM_LAYERS - 1)) begin
            reply_layer_in = '0;
            reply_ok_in    = 1'b0;
         end else begin
            scan_k_in = scan_k_ff + 1'b1;
         end
      end

      if (cmd.shift_wr) begin
         lal_we = 1'b1;
         lal_wa = k_ff[LW-1:0];
         lal_wd = lal_rd_ff;
         lol_we = 1'b1;
         lol_wa = lal_rd_ff[LW-1:0];
         lol_wd = k_ff[8:0];
         k_in   = down_ff ? (k_ff - LVL_ONE) : (k_ff + LVL_ONE);
      end

      if (cmd.final_wr) begin
         dlast_in = 2'd1;
         dnew_in  = '0;
         dk_in[0] = KIND_MAP;
         dk_in[1] = KIND_REDRAW;
         lol_we   = 1'b1;
         lol_wa   = id_idx;
         if (hid_ff) begin
            lol_wd    = '1;
            top_in    = top_ff - 9'sd1;
            dlo_in[0] = '0;
            dhi_in[0] = top_ff - 9'sd1;
            dlo_in[1] = '0;
            dhi_in[1] = old_rd_ff - 9'sd1;
         end else begin
            lal_we = 1'b1;
            lal_wa = h_ff[LW-1:0];
            lal_wd = id_ff;
            lol_wd = h_ff[8:0];
            if (ins_ff) top_in = top_ff + 9'sd1;
            if (lower_ff) begin
               dlo_in[0] = 8'(h_ff + LVL_ONE);
               dhi_in[0] = top_ff;
               dlo_in[1] = 8'(h_ff + LVL_ONE);
               dhi_in[1] = old_rd_ff;
            end else begin
               dlo_in[0] = h_ff[7:0];
               dhi_in[0] = ins_ff ? (top_ff + 9'sd1) : top_ff;
               dlo_in[1] = h_ff[7:0];
               dhi_in[1] = h_ff[8:0];
            end
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = dk_ff[e_ff];
         rsp_last_in  = (e_ff == dlast_ff);
         rsp_data_in  = pack(8'd0, 1'b1, clip(xe0, sw_ff), clip(ye0, sh_ff),
                             clip(xe1, sw_ff), clip(ye1, sh_ff),
                             dlo_ff[e_ff], dhi_ff[e_ff]);
         e_in         = e_ff + 2'd1;
      end

      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_REPLY;
         rsp_last_in  = 1'b1;
         rsp_data_in  = pack(reply_layer_ff, reply_ok_ff, '0, '0, '0, '0, 8'd0, 9'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         id_ff      <= req_tdata[7:0];
         req_lvl_ff <= req_tdata[17:8];
         nx_ff      <= req_tdata[29:18];
         ny_ff      <= req_tdata[41:30];
         nw_ff      <= req_tdata[53:42];
         nh_ff      <= req_tdata[65:54];
         old_rd_ff  <= lol_mem[cap_idx];
         ox_rd_ff   <= ox_mem[cap_idx];
         oy_rd_ff   <= oy_mem[cap_idx];
         w_rd_ff    <= w_mem[cap_idx];
         h_rd_ff    <= h_mem[cap_idx];
      end
      if (cmd.shift_rd) lal_rd_ff <= lal_mem[lal_ra];
      if (lal_we) lal_mem[lal_wa] <= lal_wd;
      if (lol_we) lol_mem[lol_wa] <= lol_wd;
      if (org_we) begin
         ox_mem[id_idx] <= nx_ff;
         oy_mem[id_idx] <= ny_ff;
      end
      if (size_we) begin
         w_mem[id_idx] <= nw_ff;
         h_mem[id_idx] <= nh_ff;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      end_ff         <= end_in;
      h_ff           <= h_in;
      down_ff        <= down_in;
      hid_ff         <= hid_in;
      ins_ff         <= ins_in;
      lower_ff       <= lower_in;
      scan_k_ff      <= scan_k_in;
      dk_ff          <= dk_in;
      dlo_ff         <= dlo_in;
      dhi_ff         <= dhi_in;
      dnew_ff        <= dnew_in;
      dlast_ff       <= dlast_in;
      e_ff           <= e_in;
      reply_layer_ff <= reply_layer_in;
      reply_ok_ff    <= reply_ok_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         top_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         sw_ff        <= SCREEN_W_RST;
         sh_ff        <= SCREEN_H_RST;
      end else begin
         slot_ff      <= slot_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SCREEN_W: sw_ff <= csr_wdata;
               CSR_SCREEN_H: sh_ff <= csr_wdata;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
